// ===== hw/rtl/bsh_pkg.sv =====
// Package for byte_stream_hash_256: constants and the controller command type.
// No dependencies.
package bsh_pkg;
    localparam logic [31:0] START_WORD  = 32'd1111111111;
    localparam logic [31:0] MIX_BIAS    = 32'd111111111;
    localparam logic [31:0] OFFSET_BIAS = 32'd11;
    localparam logic [4:0]  FIRST_SHIFT = 5'd24;
    localparam logic [4:0]  STOP_SHIFT  = 5'd9;
    localparam logic [2:0]  PREFIX_MAX  = 3'd7;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_HOLD   = 4'd1;  // store prefix byte
    localparam logic [3:0] OP_ABSORB = 4'd2;  // absorb input byte at position
    localparam logic [3:0] OP_SEED   = 4'd3;  // seed word idx (0..7)
    localparam logic [3:0] OP_PABS   = 4'd4;  // absorb prefix byte idx
    localparam logic [3:0] OP_TAIL   = 4'd5;  // tail pass at idx
    localparam logic [3:0] OP_OFFS   = 4'd6;  // cross-word offset step idx
    localparam logic [3:0] OP_ROUND  = 4'd7;  // round step for word idx

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] idx;
        logic [2:0] count;   // prefix count used by seeding
        logic [4:0] shift;
    } bsh_cmd_t;
endpackage

// ===== hw/rtl/byte_stream_hash_256.sv =====
// Top level of byte_stream_hash_256: stream ports, controller and datapath.
// Depends on bsh_pkg, bsh_ctrl, bsh_datapath.
// At most one byte is taken per transfer. The block then stays busy on a
// shared one-word update unit: seeding plus absorb of up to seven held prefix
// bytes once seven bytes are held or the message ends, a tail pass for short
// messages, the offset step and five rounds of 8 word updates. The eight
// digest words leave as eight transfers.
module byte_stream_hash_256 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast    // last_word
);
    import bsh_pkg::*;

    bsh_cmd_t   cmd;
    logic [7:0] dp_byte;
    logic [2:0] out_idx;
    logic [31:0] out_word;
    logic       in_fire;

    assign in_fire = s_tvalid && s_tready;

    bsh_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire,
        .in_byte(s_tdata), .in_has(s_tuser), .in_end(s_tlast),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_idx, .cmd, .dp_byte
    );

    bsh_datapath u_dp (
        .aclk, .cmd, .in_byte(dp_byte), .out_sel(out_idx), .out_word
    );

    assign m_tdata = {5'd0, out_idx, out_word};
    assign m_tlast = (out_idx == 3'd7);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while output pending");
    a_last_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");
`endif
endmodule

// ===== hw/rtl/bsh_datapath.sv =====
// Datapath for byte_stream_hash_256: mix/offset word registers, prefix store,
// one word operation per cycle under controller command. Uses bsh_pkg.
module bsh_datapath (
    input  logic              aclk,
    input  bsh_pkg::bsh_cmd_t cmd,
    input  logic [7:0]        in_byte,
    input  logic [2:0]        out_sel,
    output logic [31:0]       out_word
);
    import bsh_pkg::*;

    logic [31:0] m_reg [8];
    logic [31:0] o_reg [8];
    logic [7:0]  p_reg [7];

    logic [2:0]  i, nx, pv, sel;
    logic [31:0] b, v, t, mnew, onew, r1, r2;

    // round: word i updates using partners at fixed offsets from i plus one word selected by data
    // operand indexes of the round step, all mod 8
    logic [2:0] ia, ib, ic, id, ie, ig;

    always_comb begin
        i   = cmd.idx;
        nx  = i + 3'd1;
        pv  = i - 3'd1;
        b   = 32'(in_byte);
        v   = '0;
        t   = '0;
        mnew = m_reg[i];
        onew = o_reg[i];
        r1 = '0;
        r2 = '0;
        sel = '0;
        // round for m[i]: m[i] += ((m[(m[i-4]^o[6-i])&7] + (m[i-3]^o[7-i]) + o[-i]) sh)
        //                         + (m[i+1]^o[1-i])  with indices mod 8
        ia = i - 3'd4;
        ib = 3'd6 - i;
        ic = i - 3'd3;
        id = 3'd7 - i;
        ie = 3'd0 - i;
        ig = 3'd1 - i;
        case (cmd.op)
            OP_ABSORB, OP_PABS: begin
                if (cmd.op == OP_PABS) b = 32'(p_reg[i]);
                mnew = m_reg[i] + ((b + m_reg[nx] + m_reg[pv] + MIX_BIAS) << 8);
                t = ((b << 24) | (m_reg[pv] >> 8)) + mnew;
                onew = o_reg[i] ^ ((t >> 2) + mnew + b + OFFSET_BIAS);
            end
            OP_SEED: begin
                if (i == 3'd0) begin
                    mnew = START_WORD;
                end else begin
                    if (pv < cmd.count) v = 32'(p_reg[pv]) + m_reg[pv];
                    else v = m_reg[pv] + MIX_BIAS;
                    mnew = v + ((v + MIX_BIAS) << 9);
                end
                onew = mnew;
            end
            OP_TAIL: begin
                v = m_reg[i] + m_reg[nx] + MIX_BIAS;
                mnew = v + ((v + MIX_BIAS) << 9);
            end
            OP_OFFS: begin
                case (i)
                    3'd0: onew = o_reg[0] + ((m_reg[0] + o_reg[1]) ^ o_reg[0]);
                    3'd1: onew = o_reg[1] + (m_reg[1] ^ (o_reg[0] + o_reg[2]));
                    3'd2: onew = o_reg[2] + ((m_reg[2] + o_reg[3]) ^ o_reg[1]);
                    3'd3: onew = o_reg[3] + (m_reg[3] ^ (o_reg[2] + o_reg[4]));
                    3'd4: onew = o_reg[4] + ((m_reg[4] + o_reg[5]) ^ o_reg[2]);
                    3'd5: onew = o_reg[5] + (m_reg[5] ^ (o_reg[4] + o_reg[6]));
                    3'd6: onew = o_reg[6] + ((m_reg[6] + o_reg[7]) ^ o_reg[3]);
                    default: onew = o_reg[7]
                        + (((m_reg[1] ^ m_reg[2] ^ m_reg[3]) << 16)
                        | (((m_reg[4] ^ m_reg[5] ^ m_reg[6]) >> 16) + m_reg[7]));
                endcase
            end
            OP_ROUND: begin
                sel = 3'(m_reg[ia] ^ o_reg[ib]);
                r1 = m_reg[sel] + (m_reg[ic] ^ o_reg[id]) + o_reg[ie];
                r2 = i[0] ? (r1 >> cmd.shift) : (r1 << cmd.shift);
                mnew = m_reg[i] + r2 + (m_reg[nx] ^ o_reg[ig]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_HOLD) p_reg[cmd.count] <= in_byte;
        if (cmd.op != OP_NONE && cmd.op != OP_HOLD) begin
            m_reg[i] <= mnew;
            o_reg[i] <= onew;
        end
    end

    assign out_word = m_reg[out_sel];
endmodule

// ===== hw/rtl/bsh_ctrl.sv =====
// Controller for byte_stream_hash_256: holds or absorbs input bytes, sequences
// seeding, prefix absorb, tail, offset and round steps, then digest output. Uses bsh_pkg.
module bsh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    input  logic              in_has,
    input  logic              in_end,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_idx,
    output bsh_pkg::bsh_cmd_t cmd,
    output logic [7:0]        dp_byte
);
    import bsh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED  = 3'd1;
    localparam logic [2:0] S_PABS  = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_OFFS  = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       seeded_reg, seeded_next;
    logic       fin_reg, fin_next;
    logic [4:0] sh_reg, sh_next;
    logic [2:0] ridx;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_idx   = idx_reg;
    assign dp_byte   = in_byte;
    // round order 7,6,...,0
    assign ridx = 3'd7 - idx_reg;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        seeded_next = seeded_reg;
        fin_next    = fin_reg;
        sh_next     = sh_reg;
        cmd         = '{op: OP_NONE, idx: '0, count: cnt_reg, shift: sh_reg};
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    fin_next = in_end;
                    if (in_has && seeded_reg) begin
                        cmd.op = OP_ABSORB;
                        cmd.idx = pos_reg;
                        pos_next = pos_reg + 3'd1;
                        if (in_end) begin
                            state_next = S_OFFS;
                            idx_next = '0;
                        end
                    end else if (in_has) begin
                        cmd.op = OP_HOLD;
                        cmd.count = cnt_reg;
                        cnt_next = cnt_reg + 3'd1;
                        state_next = S_SEED;
                        idx_next = '0;
                        if (cnt_reg != PREFIX_MAX - 3'd1 && !in_end) state_next = S_IDLE;
                    end else if (in_end) begin
                        state_next = seeded_reg ? S_OFFS : S_SEED;
                        idx_next = '0;
                    end
                end
            end
            S_SEED: begin
                cmd.op = OP_SEED;
                cmd.idx = idx_reg;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    idx_next = '0;
                    state_next = (cnt_reg == 3'd0) ? S_TAIL : S_PABS;
                end
            end
            S_PABS: begin
                cmd.op = OP_PABS;
                cmd.idx = idx_reg;
                idx_next = idx_reg + 3'd1;
                if (idx_reg + 3'd1 == cnt_reg) begin
                    seeded_next = 1'b1;
                    pos_next = cnt_reg;
                    idx_next = cnt_reg;
                    state_next = fin_reg ? S_TAIL : S_IDLE;
                    if (fin_reg && cnt_reg == PREFIX_MAX) begin
                        state_next = S_OFFS;
                        idx_next = '0;
                    end
                end
            end
            S_TAIL: begin
                cmd.op = OP_TAIL;
                cmd.idx = idx_reg;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd6) begin
                    idx_next = '0;
                    state_next = S_OFFS;
                end
            end
            S_OFFS: begin
                cmd.op = OP_OFFS;
                cmd.idx = idx_reg;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    idx_next = '0;
                    sh_next = FIRST_SHIFT;
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.op = OP_ROUND;
                cmd.idx = ridx;
                cmd.shift = sh_reg;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    idx_next = '0;
                    sh_next = sh_reg - 5'd3;
                    if (sh_reg - 5'd3 == STOP_SHIFT) state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        idx_next = '0;
                        state_next = S_IDLE;
                        pos_next = '0;
                        cnt_next = '0;
                        seeded_next = 1'b0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            seeded_reg <= 1'b0;
            fin_reg    <= 1'b0;
            sh_reg     <= FIRST_SHIFT;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            seeded_reg <= seeded_next;
            fin_reg    <= fin_next;
            sh_reg     <= sh_next;
        end
    end
endmodule
